[hdl/imm_pkg.sv]
`default_nettype none

package imm_pkg;

  // Fixed field widths.
  localparam int DIM_W     = 7;
  localparam int RUN_AW    = 2 * DIM_W;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 22;
  localparam int CFG_IDX_W = 3;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_READ_C = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PACKED   = 3'd6;

  // Configuration register file contents.
  typedef struct packed {
    logic [DIM_W-1:0] rows_m;
    logic [DIM_W-1:0] inner_k;
    logic [DIM_W-1:0] cols_n;
    logic [DIM_W-1:0] stride_a;
    logic [DIM_W-1:0] stride_b;
    logic [DIM_W-1:0] stride_c;
    logic             packed_layout;
  } cfg_t;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

  // Run status from the sequencer to the request logic.
  typedef struct packed {
    logic busy;
    logic fin;
    logic err;
  } run_stat_t;

endpackage

`default_nettype wire

[hdl/int8_matrix_multiply.sv]
`default_nettype none

// Signed 8-bit matrix multiply with 22-bit exact accumulation, C = A x B.
// Command channel: a transaction is taken when start is high and busy is low.
// req_type selects a load of one A or B byte, a run, or a read of one C word.
// Loads give no result; back-to-back loads stream.
// A read's result passes through the C store read register and then the
// result register, with done high for one cycle; reads stream one per cycle
// while busy is low. A read outside the store returns zero with status high.
// A run holds busy through the address bound checks on one shared multiplier,
// then one dot product at a time with the A and B read ports giving one term
// per cycle, and the DRAIN1 and DRAIN2 states covering the read and multiply
// latency of each element before its write to C. Its result (word_value
// zero, status high on an address or size error) comes in the same cycle in
// which busy falls. A failed check writes nothing to C.
// After reset the C store is zeroed by a pass over all STORE_DEPTH words,
// during which busy is high; configuration writes are taken at any time.
// Results cannot be held off by the receiver.
module int8_matrix_multiply
  import imm_pkg::*;
#(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_DIM = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic        [1:0]           req_type,
  input  wire logic        [11:0]          address,
  input  wire logic signed [BYTE_W-1:0]    byte_value,
  output logic                             done,
  output logic signed      [WORD_W-1:0]    word_value,
  output logic                             status,
  input  wire logic                        cfg_we,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [DIM_W-1:0]     cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  cfg_t                     cfg;
  run_stat_t                stat;
  mac_ctl_t                 mac_ctl;
  req_t                     req;
  logic                     accept;
  logic                     in_range;
  logic        [AW-1:0]     req_idx;
  logic                     run_go;
  logic                     a_we;
  logic                     b_we;
  logic                     rd_pend;
  logic                     rd_oob;
  logic        [AW-1:0]     a_raddr;
  logic        [AW-1:0]     b_raddr;
  logic signed [BYTE_W-1:0] a_rdata;
  logic signed [BYTE_W-1:0] b_rdata;
  logic                     c_we;
  logic        [AW-1:0]     c_waddr;
  logic        [WORD_W-1:0] c_wdata;
  logic        [WORD_W-1:0] c_rdata;
  logic signed [WORD_W-1:0] acc;

  // Request decode.
  assign req      = req_t'(req_type);
  assign busy     = stat.busy;
  assign accept   = start && !stat.busy;
  assign in_range = (32'(address) < 32'(STORE_DEPTH));
  assign req_idx  = AW'(address);
  assign run_go   = accept && (req == REQ_RUN);
  assign a_we     = accept && (req == REQ_LOAD_A) && in_range;
  assign b_we     = accept && (req == REQ_LOAD_B) && in_range;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_m        <= 7'd1;
      cfg.inner_k       <= 7'd1;
      cfg.cols_n        <= 7'd1;
      cfg.stride_a      <= 7'd1;
      cfg.stride_b      <= 7'd1;
      cfg.stride_c      <= 7'd1;
      cfg.packed_layout <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_M:   cfg.rows_m        <= cfg_data;
        REG_INNER_K:  cfg.inner_k       <= cfg_data;
        REG_COLS_N:   cfg.cols_n        <= cfg_data;
        REG_STRIDE_A: cfg.stride_a      <= cfg_data;
        REG_STRIDE_B: cfg.stride_b      <= cfg_data;
        REG_STRIDE_C: cfg.stride_c      <= cfg_data;
        REG_PACKED:   cfg.packed_layout <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Read pipeline and result register; read and run results never coincide.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      rd_oob  <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_pend <= accept && (req == REQ_READ_C) && in_range;
      rd_oob  <= accept && (req == REQ_READ_C) && !in_range;
      done    <= rd_pend || rd_oob || stat.fin;
    end
  end

  always_ff @(posedge clk) begin
    word_value <= rd_pend ? c_rdata : '0;
    status     <= rd_oob || (stat.fin && stat.err);
  end

  // Element stores.
  imm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (req_idx),
    .wdata (byte_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  imm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (req_idx),
    .wdata (byte_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  imm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (req_idx),
    .rdata (c_rdata)
  );

  // Run sequencer and multiply-accumulate unit.
  imm_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_DIM     (MAX_DIM)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .run_go  (run_go),
    .cfg     (cfg),
    .acc     (acc),
    .stat    (stat),
    .mac_ctl (mac_ctl),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .c_we    (c_we),
    .c_waddr (c_waddr),
    .c_wdata (c_wdata)
  );

  imm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .acc    (acc)
  );

`ifndef SYNTHESIS
  // A read result and a run result must never fall in the same cycle.
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    !((rd_pend || rd_oob) && stat.fin))
    else $error("read result and run result collide");

  // A finished run frees the command channel in the next cycle.
  a_fin_frees: assert property (@(posedge clk) disable iff (rst)
    stat.fin |=> !busy)
    else $error("busy still high after a run finished");

  // A taken run makes the block busy once the sequencer leaves its idle state.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    run_go |=> busy)
    else $error("run taken but block not busy");
`endif

endmodule

`default_nettype wire

[hdl/imm_ram.sv]
`default_nettype none

module imm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/imm_mac.sv]
`default_nettype none

module imm_mac
  import imm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [BYTE_W-1:0] a_data,
  input  wire logic signed [BYTE_W-1:0] b_data,
  output logic signed      [WORD_W-1:0] acc
);

  logic                       v1;
  logic                       v2;
  logic signed [2*BYTE_W-1:0] prod;

  // Valid bits follow the read latency and the product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
    end
  end

  // Product register, then accumulation; clear starts a new dot product.
  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (ctl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + WORD_W'(prod);
    end
  end

endmodule

`default_nettype wire

[hdl/imm_ctrl.sv]
`default_nettype none

module imm_ctrl
  import imm_pkg::*;
#(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_DIM = 64,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     run_go,
  input  wire cfg_t                     cfg,
  input  wire logic signed [WORD_W-1:0] acc,
  output run_stat_t                     stat,
  output mac_ctl_t                      mac_ctl,
  output logic             [AW-1:0]     a_raddr,
  output logic             [AW-1:0]     b_raddr,
  output logic                          c_we,
  output logic             [AW-1:0]     c_waddr,
  output logic             [WORD_W-1:0] c_wdata
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_VERIFY,
    ST_ISSUE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_WRITE
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_idx;
  logic [1:0]        chk_cnt;
  logic [RUN_AW-1:0] chk_bound;
  logic              chk_live;
  logic              bad;
  logic [DIM_W-1:0]  i;
  logic [DIM_W-1:0]  j;
  logic [DIM_W-1:0]  p;
  logic [RUN_AW-1:0] a_row;
  logic [RUN_AW-1:0] c_row;
  logic [RUN_AW-1:0] a_ptr;
  logic [RUN_AW-1:0] b_ptr;

  logic [DIM_W-1:0]  pa;
  logic [DIM_W-1:0]  pb;
  logic [DIM_W-1:0]  pc;
  logic [DIM_W-1:0]  mul_x;
  logic [DIM_W-1:0]  mul_y;
  logic [DIM_W-1:0]  add_z;
  logic              live;
  logic [RUN_AW-1:0] chk_prod;
  logic [RUN_AW-1:0] chk_sum;
  logic              dim_bad;
  logic              empty;
  logic              last_i;
  logic              last_j;
  logic [DIM_W-1:0]  i_next;
  logic [DIM_W-1:0]  j_next;
  logic [RUN_AW-1:0] a_row_next;
  logic [RUN_AW-1:0] c_row_next;
  logic [RUN_AW-1:0] c_addr;

  // Row pitches for the selected layout.
  assign pa = cfg.packed_layout ? cfg.inner_k : cfg.stride_a;
  assign pb = cfg.packed_layout ? cfg.cols_n : cfg.stride_b;
  assign pc = cfg.packed_layout ? cfg.cols_n : cfg.stride_c;

  assign dim_bad = (32'(cfg.rows_m) > 32'(MAX_DIM)) || (32'(cfg.inner_k) > 32'(MAX_DIM)) ||
                   (32'(cfg.cols_n) > 32'(MAX_DIM));
  assign empty   = (cfg.rows_m == '0) || (cfg.cols_n == '0);

  // Shared bound unit: the last address of A, B and C in turn.
  always_comb begin
    case (chk_cnt)
      2'd0: begin
        mul_x = cfg.rows_m - 7'd1;
        mul_y = pa;
        add_z = cfg.inner_k - 7'd1;
        live  = (cfg.rows_m != '0) && (cfg.inner_k != '0);
      end
      2'd1: begin
        mul_x = cfg.inner_k - 7'd1;
        mul_y = pb;
        add_z = cfg.cols_n - 7'd1;
        live  = (cfg.inner_k != '0) && (cfg.cols_n != '0);
      end
      default: begin
        mul_x = cfg.rows_m - 7'd1;
        mul_y = pc;
        add_z = cfg.cols_n - 7'd1;
        live  = (cfg.rows_m != '0) && (cfg.cols_n != '0);
      end
    endcase
  end

  assign chk_prod = mul_x * mul_y;
  assign chk_sum  = chk_prod + RUN_AW'(add_z);

  // Loop stepping after each written C element.
  assign last_i     = (i == cfg.rows_m - 7'd1);
  assign last_j     = (j == cfg.cols_n - 7'd1);
  assign j_next     = last_j ? '0 : j + 7'd1;
  assign i_next     = last_j ? i + 7'd1 : i;
  assign a_row_next = last_j ? a_row + RUN_AW'(pa) : a_row;
  assign c_row_next = last_j ? c_row + RUN_AW'(pc) : c_row;
  assign c_addr     = c_row + RUN_AW'(j);

  // Sequencer: clearing pass, bound checks, then the i, j, p loops.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      chk_cnt <= '0;
      bad     <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (run_go) begin
            state   <= ST_CHECK;
            chk_cnt <= '0;
            bad     <= dim_bad;
          end
        end
        ST_CHECK: begin
          chk_bound <= chk_sum;
          chk_live  <= live;
          if (chk_cnt != 2'd0 && chk_live && (32'(chk_bound) >= 32'(STORE_DEPTH))) begin
            bad <= 1'b1;
          end
          chk_cnt <= chk_cnt + 2'd1;
          if (chk_cnt == 2'd3) begin
            state <= ST_VERIFY;
          end
        end
        ST_VERIFY: begin
          i     <= '0;
          j     <= '0;
          p     <= '0;
          a_row <= '0;
          c_row <= '0;
          a_ptr <= '0;
          b_ptr <= '0;
          if (bad || empty) begin
            state <= ST_IDLE;
          end else if (cfg.inner_k == '0) begin
            state <= ST_WRITE;
          end else begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          a_ptr <= a_ptr + 1'b1;
          b_ptr <= b_ptr + RUN_AW'(pb);
          p     <= p + 7'd1;
          if (p == cfg.inner_k - 7'd1) begin
            state <= ST_DRAIN1;
          end
        end
        ST_DRAIN1: begin
          state <= ST_DRAIN2;
        end
        ST_DRAIN2: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (last_i && last_j) begin
            state <= ST_IDLE;
          end else begin
            i     <= i_next;
            j     <= j_next;
            a_row <= a_row_next;
            c_row <= c_row_next;
            p     <= '0;
            a_ptr <= a_row_next;
            b_ptr <= RUN_AW'(j_next);
            state <= (cfg.inner_k == '0) ? ST_WRITE : ST_ISSUE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Status, accumulator control and memory ports.
  assign stat.busy = (state != ST_IDLE);
  assign stat.fin  = ((state == ST_VERIFY) && (bad || empty)) ||
                     ((state == ST_WRITE) && last_i && last_j);
  assign stat.err  = (state == ST_VERIFY) && bad;

  assign mac_ctl.issue = (state == ST_ISSUE);
  assign mac_ctl.clear = (state == ST_VERIFY) || (state == ST_WRITE);

  assign a_raddr = AW'(a_ptr);
  assign b_raddr = AW'(b_ptr);
  assign c_we    = (state == ST_CLEAR) || (state == ST_WRITE);
  assign c_waddr = (state == ST_CLEAR) ? clr_idx : AW'(c_addr);
  assign c_wdata = (state == ST_CLEAR) ? '0 : acc;

`ifndef SYNTHESIS
  // The bound checks keep every run access inside the stores.
  a_issue_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (32'(a_ptr) < 32'(STORE_DEPTH)) &&
                            (32'(b_ptr) < 32'(STORE_DEPTH)))
    else $error("run read outside the A or B store");

  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (32'(c_addr) < 32'(STORE_DEPTH)))
    else $error("run write outside the C store");
`endif

endmodule

`default_nettype wire
